### sv/meb_pkg.sv
`timescale 1ns / 1ps
// meb_pkg: constants, state and control types of the escape band block
// no dependencies; imported by meb_mac, meb_seq, mandelbrot_escape_band and tb_mandelbrot_escape_band
package meb_pkg;

   localparam int ITER_LIMIT     = 1000;
   localparam int FRAC_BITS      = 58;
   localparam int BAND_DIV       = 124;
   localparam int NO_ESCAPE_BAND = 9;
   localparam int ESC_RADIUS_SQ  = 10;

   localparam int WORD_W  = 64;
   localparam int HALF_W  = WORD_W / 2;
   localparam int WIDE_W  = 2 * WORD_W;
   localparam int BAND_W  = 4;
   localparam int STEP_W  = $clog2(ITER_LIMIT + 1);
   localparam int SUB_W   = $clog2(BAND_DIV + 1);
   localparam int PART_W  = 2;
   localparam int CNT_W   = 3;
   localparam int MAC_LAST = 4;

   localparam logic [WIDE_W-1:0] ESC_LIMIT =
      WIDE_W'(ESC_RADIUS_SQ) << (2 * FRAC_BITS);

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_MXY  = 7'b0000010,
      ST_UPT  = 7'b0000100,
      ST_UPZ  = 7'b0001000,
      ST_MSX  = 7'b0010000,
      ST_MSY  = 7'b0100000,
      ST_CHK  = 7'b1000000
   } state_type;

   typedef enum logic [1:0] {
      OP_XY = 2'd0,
      OP_SX = 2'd1,
      OP_SY = 2'd2
   } op_sel_type;

   typedef struct packed {
      logic              load;
      logic              mac_clear;
      logic              mac_issue;
      logic [PART_W-1:0] mac_part;
      op_sel_type        op_sel;
      logic              upd_t;
      logic              upd_z;
      logic              save_sx;
      logic              save_sy;
   } ctrl_type;

   typedef struct packed {
      logic sat;
      logic esc;
   } status_type;

endpackage

### sv/meb_mac.sv
`timescale 1ns / 1ps
// meb_mac: shared 32x32 multiplier with registered product and 128-bit accumulator
// forms a 64x64 unsigned product from four partial products; uses meb_pkg
module meb_mac
   import meb_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic [WORD_W-1:0] op_a,
   input  logic [WORD_W-1:0] op_b,
   input  logic              clear,
   input  logic              issue,
   input  logic [PART_W-1:0] part,
   output logic [WIDE_W-1:0] acc
);

   logic [HALF_W-1:0] a_half;
   logic [HALF_W-1:0] b_half;
   logic [WORD_W-1:0] prod_ff, prod_in;
   logic [1:0]        shift_ff, shift_in;
   logic              vld_ff;
   logic [WIDE_W-1:0] acc_ff, acc_in;
   logic [6:0]        shamt;

   assign a_half   = part[1] ? op_a[WORD_W-1:HALF_W] : op_a[HALF_W-1:0];
   assign b_half   = part[0] ? op_b[WORD_W-1:HALF_W] : op_b[HALF_W-1:0];
   assign prod_in  = WORD_W'(a_half) * WORD_W'(b_half);
   assign shift_in = 2'(part[1]) + 2'(part[0]);
   assign shamt    = {shift_ff, 5'b0};

   always_comb begin
      acc_in = acc_ff;
      if (clear) begin
         acc_in = '0;
      end else if (vld_ff) begin
         acc_in = acc_ff + (WIDE_W'(prod_ff) << shamt);
      end
   end

   always_ff @(posedge clock) begin
      prod_ff  <= prod_in;
      shift_ff <= shift_in;
      acc_ff   <= acc_in;
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= issue;
      end
   end

   assign acc = acc_ff;

   // clearing never drops a pending partial product
   a_clear_drained: assert property (@(posedge clock) disable iff (reset)
      clear |-> !vld_ff) else $error("accumulator cleared with partial in flight");
   // an issued partial product is registered with its valid flag on the next edge
   a_issue_adds: assert property (@(posedge clock) disable iff (reset)
      issue && !clear |=> vld_ff) else $error("issued partial not accumulated");
   // the top partial never lands above 2^64 alignment
   a_shift_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff |-> shift_ff != 2'd3) else $error("bad partial alignment");

endmodule

### sv/meb_seq.sv
`timescale 1ns / 1ps
// meb_seq: sequencer for one escape-time point, step and band counters
// drives meb_mac and the datapath in mandelbrot_escape_band; uses meb_pkg
module meb_seq
   import meb_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  status_type        status,
   output ctrl_type          ctrl,
   output logic              busy,
   output logic              rsp_valid,
   output logic [BAND_W-1:0] rsp_band
);

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [SUB_W-1:0]  sub_ff, sub_in;
   logic [BAND_W-1:0] bcnt_ff, bcnt_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [BAND_W-1:0] rsp_band_ff, rsp_band_in;
   logic              accept;
   logic              mac_last;

   assign accept   = start && (state_ff == ST_IDLE);
   assign mac_last = (cnt_ff == CNT_W'(MAC_LAST));

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      step_in      = step_ff;
      sub_in       = sub_ff;
      bcnt_in      = bcnt_ff;
      rsp_valid_in = 1'b0;
      rsp_band_in  = rsp_band_ff;
      ctrl         = '0;
      ctrl.op_sel  = OP_XY;
      ctrl.mac_issue = (cnt_ff < CNT_W'(MAC_LAST));
      ctrl.mac_clear = (cnt_ff == '0);
      ctrl.mac_part  = cnt_ff[PART_W-1:0];
      case (state_ff)
         ST_IDLE: begin
            ctrl.mac_issue = 1'b0;
            ctrl.mac_clear = 1'b0;
            if (accept) begin
               ctrl.load = 1'b1;
               cnt_in    = '0;
               step_in   = '0;
               sub_in    = '0;
               bcnt_in   = '0;
               state_in  = ST_MXY;
            end
         end
         ST_MXY, ST_MSX, ST_MSY: begin
            if (state_ff == ST_MSX) begin
               ctrl.op_sel = OP_SX;
            end else if (state_ff == ST_MSY) begin
               ctrl.op_sel = OP_SY;
               // square of x is in the accumulator on entry
               ctrl.save_sx = (cnt_ff == '0);
            end
            cnt_in = cnt_ff + CNT_W'(1);
            if (mac_last) begin
               cnt_in = '0;
               case (state_ff)
                  ST_MXY:  state_in = ST_UPT;
                  ST_MSX:  state_in = ST_MSY;
                  default: state_in = ST_CHK;
               endcase
            end
         end
         ST_UPT: begin
            ctrl.mac_issue = 1'b0;
            ctrl.mac_clear = 1'b0;
            ctrl.upd_t     = 1'b1;
            state_in       = ST_UPZ;
         end
         ST_UPZ: begin
            ctrl.mac_issue = 1'b0;
            ctrl.mac_clear = 1'b0;
            ctrl.upd_z     = 1'b1;
            if (status.sat) begin
               rsp_valid_in = 1'b1;
               rsp_band_in  = bcnt_ff;
               state_in     = ST_IDLE;
            end else begin
               state_in = ST_MSX;
            end
         end
         ST_CHK: begin
            ctrl.mac_issue = 1'b0;
            ctrl.mac_clear = 1'b0;
            ctrl.save_sy   = 1'b1;
            if (status.esc) begin
               rsp_valid_in = 1'b1;
               rsp_band_in  = bcnt_ff;
               state_in     = ST_IDLE;
            end else if (step_ff == STEP_W'(ITER_LIMIT - 1)) begin
               rsp_valid_in = 1'b1;
               rsp_band_in  = BAND_W'(NO_ESCAPE_BAND);
               state_in     = ST_IDLE;
            end else begin
               step_in = step_ff + STEP_W'(1);
               if (sub_ff == SUB_W'(BAND_DIV - 1)) begin
                  sub_in  = '0;
                  bcnt_in = bcnt_ff + BAND_W'(1);
               end else begin
                  sub_in = sub_ff + SUB_W'(1);
               end
               state_in = ST_MXY;
            end
         end
         default: begin
            ctrl.mac_issue = 1'b0;
            ctrl.mac_clear = 1'b0;
            state_in       = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         step_ff      <= '0;
         sub_ff       <= '0;
         bcnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         rsp_band_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         step_ff      <= step_in;
         sub_ff       <= sub_in;
         bcnt_ff      <= bcnt_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_band_ff  <= rsp_band_in;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_band  = rsp_band_ff;

   // a word goes out only as the sequencer drops back to idle
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> state_ff == ST_IDLE) else $error("word out while busy");
   // an accepted point starts with the cross product
   a_accept_mxy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> state_ff == ST_MXY && step_ff == '0)
      else $error("accepted point did not start");
   // band is an escape band or the no-escape code
   a_band_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_band_ff <= BAND_W'(NO_ESCAPE_BAND))
      else $error("band out of range");
   // step counter never passes the iteration limit
   a_step_range: assert property (@(posedge clock) disable iff (reset)
      step_ff < STEP_W'(ITER_LIMIT)) else $error("step count past limit");
   // partial counter stays within the multiply sweep
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAC_LAST)) else $error("partial counter out of range");

endmodule

### sv/mandelbrot_escape_band.sv
`timescale 1ns / 1ps
// mandelbrot_escape_band: escape-time band of one complex point in Q5.58
// instantiates meb_seq and meb_mac; uses meb_pkg
//
// usage:
//   a point (req_c_real, req_c_imag) is taken at a rising edge with start high
//   and busy low; busy stays high until the point is finished
//   z = z*z + c is iterated from zero, one step per pass of the sequencer;
//   each step runs three 64x64 products through one 32x32 multiplier, four
//   partials each plus a drain: the cross product, an update of t, an update
//   of z, the squares of x and y, then the escape check
//   an escape by magnitude is found at the check and an overflow of z at the
//   update of z; either returns the band of that step, and a point that never
//   escapes runs all 1000 steps and returns band 9
//   the result word (rsp_band) is shown for exactly one cycle with rsp_valid;
//   the receiver cannot stall it, and busy is already low in that cycle so a
//   new point may be started then
//   synchronous reset returns the sequencer to idle and drops rsp_valid; the
//   datapath registers of the point are not reset
module mandelbrot_escape_band
   import meb_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic signed [WORD_W-1:0] req_c_real,
   input  logic signed [WORD_W-1:0] req_c_imag,
   output logic                     rsp_valid,
   output logic [BAND_W-1:0]        rsp_band
);

   ctrl_type          ctrl;
   status_type        status;
   logic [WIDE_W-1:0] acc;

   logic [WORD_W-1:0] cr_ff, ci_ff;
   logic [WORD_W-1:0] x_ff, y_ff;
   logic [WIDE_W-1:0] sqx_ff, sqy_ff;
   logic signed [WIDE_W-1:0] tre_ff, tre_in;
   logic signed [WIDE_W-1:0] tim_ff, tim_in;

   logic [WORD_W-1:0] mag_x, mag_y;
   logic [WORD_W-1:0] op_a, op_b;
   logic signed [WIDE_W-1:0] diff;
   logic signed [WIDE_W-1:0] prod_s;
   logic [WIDE_W-1:0] nx, ny;
   logic [WIDE_W-1:0] mag_sum;

   assign mag_x = x_ff[WORD_W-1] ? (~x_ff + WORD_W'(1)) : x_ff;
   assign mag_y = y_ff[WORD_W-1] ? (~y_ff + WORD_W'(1)) : y_ff;

   always_comb begin
      case (ctrl.op_sel)
         OP_XY: begin
            op_a = mag_x;
            op_b = mag_y;
         end
         OP_SX: begin
            op_a = mag_x;
            op_b = mag_x;
         end
         OP_SY: begin
            op_a = mag_y;
            op_b = mag_y;
         end
         default: begin
            op_a = mag_x;
            op_b = mag_y;
         end
      endcase
   end

   meb_mac u_mac (
      .clock (clock),
      .reset (reset),
      .op_a  (op_a),
      .op_b  (op_b),
      .clear (ctrl.mac_clear),
      .issue (ctrl.mac_issue),
      .part  (ctrl.mac_part),
      .acc   (acc)
   );

   // floor-shifted real and imaginary terms
   assign diff   = signed'(sqx_ff - sqy_ff);
   assign prod_s = (x_ff[WORD_W-1] ^ y_ff[WORD_W-1]) ? signed'(~acc + WIDE_W'(1))
                                                     : signed'(acc);
   assign tre_in = diff >>> FRAC_BITS;
   assign tim_in = prod_s >>> (FRAC_BITS - 1);

   assign nx = unsigned'(tre_ff) + {{WORD_W{cr_ff[WORD_W-1]}}, cr_ff};
   assign ny = unsigned'(tim_ff) + {{WORD_W{ci_ff[WORD_W-1]}}, ci_ff};

   assign status.sat = !((&nx[WIDE_W-1:WORD_W-1]) || !(|nx[WIDE_W-1:WORD_W-1])) ||
                       !((&ny[WIDE_W-1:WORD_W-1]) || !(|ny[WIDE_W-1:WORD_W-1]));

   assign mag_sum    = sqx_ff + acc;
   assign status.esc = (mag_sum > ESC_LIMIT);

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         cr_ff  <= req_c_real;
         ci_ff  <= req_c_imag;
         x_ff   <= '0;
         y_ff   <= '0;
         sqx_ff <= '0;
         sqy_ff <= '0;
      end else begin
         if (ctrl.upd_z) begin
            x_ff <= nx[WORD_W-1:0];
            y_ff <= ny[WORD_W-1:0];
         end
         if (ctrl.save_sx) begin
            sqx_ff <= acc;
         end
         if (ctrl.save_sy) begin
            sqy_ff <= acc;
         end
      end
      if (ctrl.upd_t) begin
         tre_ff <= tre_in;
         tim_ff <= tim_in;
      end
   end

   meb_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .status    (status),
      .ctrl      (ctrl),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .rsp_band  (rsp_band)
   );

   // a new point is only loaded when the block was idle
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      ctrl.load |-> !busy) else $error("point loaded while busy");
   // an update of z is never directly followed by another update of z or of t
   a_one_update: assert property (@(posedge clock) disable iff (reset)
      ctrl.upd_z |=> !ctrl.upd_z && !ctrl.upd_t) else $error("double update of z");
   // the stored squares never reach 2^127, so the sum cannot wrap
   a_sum_no_wrap: assert property (@(posedge clock) disable iff (reset)
      ctrl.save_sy |-> !sqx_ff[WIDE_W-1] && !acc[WIDE_W-1])
      else $error("square out of range");

endmodule

### tb/tb_mandelbrot_escape_band.sv
`timescale 1ns / 1ps
// tb_mandelbrot_escape_band: self-checking bench for the escape band block
// drives a directed table of points and then random points, and checks every band word against
// its typed-in band or its own fixed-point escape predictor; depends on meb_pkg and mandelbrot_escape_band
module tb_mandelbrot_escape_band;
   import meb_pkg::*;

   typedef struct packed {
      logic signed [WORD_W-1:0] re;
      logic signed [WORD_W-1:0] im;
      logic [BAND_W-1:0]        band;
      logic                     known;
   } point_type;

   localparam logic [BAND_W-1:0]        NEVER_BAND = BAND_W'(NO_ESCAPE_BAND);
   localparam logic [BAND_W-1:0]        FIRST_BAND = '0;
   localparam logic signed [WORD_W-1:0] Q_ONE      = 64'sh0400_0000_0000_0000;
   localparam logic signed [WORD_W-1:0] Q_QUARTER  = 64'sh0100_0000_0000_0000;
   localparam logic signed [WORD_W-1:0] Q_MAX      = 64'sh7fff_ffff_ffff_ffff;
   localparam logic signed [WORD_W-1:0] Q_MIN      = 64'sh8000_0000_0000_0000;
   localparam int N_DIRECTED = 24;
   localparam int N_RANDOM   = 600;

   // expected band typed in only where it is obvious, others use the predictor
   localparam point_type DIRECTED [N_DIRECTED] = '{
      '{64'sd0, 64'sd0, NEVER_BAND, 1'b1},
      '{Q_MAX, Q_MAX, FIRST_BAND, 1'b1},
      '{Q_MIN, Q_MIN, FIRST_BAND, 1'b1},
      '{Q_MAX, Q_MIN, FIRST_BAND, 1'b1},
      '{Q_MIN, Q_MAX, FIRST_BAND, 1'b1},
      '{-2 * Q_ONE, 64'sd0, NEVER_BAND, 1'b1},
      '{3 * Q_ONE, Q_ONE, FIRST_BAND, 1'b1},
      '{Q_ONE, 3 * Q_ONE, FIRST_BAND, 1'b1},
      '{-Q_ONE, 64'sd0, NEVER_BAND, 1'b1},
      '{64'sd0, Q_ONE, NEVER_BAND, 1'b1},
      '{64'sd0, -Q_ONE, NEVER_BAND, 1'b1},
      '{4 * Q_ONE, 64'sd0, FIRST_BAND, 1'b1},
      '{64'sd0, -4 * Q_ONE, FIRST_BAND, 1'b1},
      '{Q_QUARTER, 64'sd0, FIRST_BAND, 1'b0},
      '{-3 * Q_QUARTER, 64'sd0, FIRST_BAND, 1'b0},
      '{64'sd1, 64'sd0, FIRST_BAND, 1'b0},
      '{-64'sd1, -64'sd1, FIRST_BAND, 1'b0},
      '{Q_QUARTER + 64'sh0000_4000_0000_0000, 64'sd0, FIRST_BAND, 1'b0},
      '{Q_QUARTER + 64'sh0000_1000_0000_0000, 64'sd0, FIRST_BAND, 1'b0},
      '{Q_QUARTER + 64'sh0000_0400_0000_0000, 64'sd0, FIRST_BAND, 1'b0},
      '{-7 * Q_QUARTER, 64'sd0, FIRST_BAND, 1'b0},
      '{-2 * Q_QUARTER, 64'sh0266_6666_6666_6666, FIRST_BAND, 1'b0},
      '{64'shaaaa_aaaa_aaaa_aaaa, 64'sh5555_5555_5555_5555, FIRST_BAND, 1'b0},
      '{64'sh5555_5555_5555_5555, 64'shaaaa_aaaa_aaaa_aaaa, FIRST_BAND, 1'b0}
   };

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic                     busy;
   logic signed [WORD_W-1:0] req_c_real = '0;
   logic signed [WORD_W-1:0] req_c_imag = '0;
   logic                     rsp_valid;
   logic [BAND_W-1:0]        rsp_band;

   point_type pending_bands [$];
   int        band_errors = 0;

   mandelbrot_escape_band dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_c_real (req_c_real),
      .req_c_imag (req_c_imag),
      .rsp_valid  (rsp_valid),
      .rsp_band   (rsp_band)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic logic [BAND_W-1:0] escape_band_of(input logic signed [WORD_W-1:0] cr,
                                                        input logic signed [WORD_W-1:0] ci);
      logic signed [WIDE_W-1:0] zr;
      logic signed [WIDE_W-1:0] zi;
      logic signed [WIDE_W-1:0] nr;
      logic signed [WIDE_W-1:0] ni;
      logic [WIDE_W-1:0]        mag_sq;
      logic [BAND_W-1:0]        band;
      int                       n;
      zr = '0;
      zi = '0;
      band = NEVER_BAND;
      for (n = 0; n < ITER_LIMIT; n++) begin
         nr = ((zr * zr - zi * zi) >>> FRAC_BITS) + cr;
         ni = ((zr * zi) >>> (FRAC_BITS - 1)) + ci;
         // out of the 64-bit range counts as an escape
         if (nr[WIDE_W-1:WORD_W-1] != {(WORD_W+1){nr[WORD_W-1]}} ||
             ni[WIDE_W-1:WORD_W-1] != {(WORD_W+1){ni[WORD_W-1]}}) begin
            band = BAND_W'(n / BAND_DIV);
            break;
         end
         zr = nr;
         zi = ni;
         mag_sq = zr * zr + zi * zi;
         if (mag_sq > ESC_LIMIT) begin
            band = BAND_W'(n / BAND_DIV);
            break;
         end
      end
      return band;
   endfunction

   task automatic drive_point(input logic signed [WORD_W-1:0] re,
                              input logic signed [WORD_W-1:0] im,
                              input logic known, input logic [BAND_W-1:0] band);
      point_type entry;
      @(negedge clock);
      start <= 1'b1;
      req_c_real <= re;
      req_c_imag <= im;
      do @(posedge clock); while (busy !== 1'b0);
      entry.re = re;
      entry.im = im;
      entry.known = known;
      entry.band = known ? band : escape_band_of(re, im);
      pending_bands.push_back(entry);
   endtask

   task automatic hold_off(input int cycles);
      int k;
      for (k = 0; k < cycles; k++) begin
         @(negedge clock);
         start <= 1'b0;
         req_c_real <= {$urandom, $urandom};
         req_c_imag <= {$urandom, $urandom};
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_bands.size() == 0) begin
            band_errors++;
            if (band_errors <= 10)
               $display("unexpected band word %0d", rsp_band);
         end else begin
            if (rsp_band !== pending_bands[0].band) begin
               band_errors++;
               if (band_errors <= 10)
                  $display("band mismatch c=(%h, %h): expected %0d, got %0d",
                           pending_bands[0].re, pending_bands[0].im,
                           pending_bands[0].band, rsp_band);
            end
            void'(pending_bands.pop_front());
         end
      end
   end

   initial begin
      #250_000_000;
      $display("tb_mandelbrot_escape_band NOT OK");
      $finish;
   end

   initial begin
      logic [WORD_W-1:0]        rnd_re;
      logic [WORD_W-1:0]        rnd_im;
      logic [WORD_W-1:0]        eps;
      logic signed [WORD_W-1:0] re;
      logic signed [WORD_W-1:0] im;
      int                       i;
      int                       kind;
      int                       shift;
      int                       burst_left;
      int                       waited;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      for (i = 0; i < N_DIRECTED; i++) begin
         drive_point(DIRECTED[i].re, DIRECTED[i].im, DIRECTED[i].known, DIRECTED[i].band);
         hold_off($urandom_range(0, 3));
      end

      burst_left = 0;
      for (i = 0; i < N_RANDOM; i++) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 3) != 0)
               hold_off($urandom_range(1, 30));
         end
         burst_left--;
         rnd_re = {$urandom, $urandom};
         rnd_im = {$urandom, $urandom};
         kind = $urandom_range(0, 99);
         if (kind < 55) begin
            re = rnd_re;
            im = rnd_im;
         end else if (kind < 67) begin
            // box around the set, -2.25..0.75 by -1.5..1.5
            re = (rnd_re % (64'd12 << 56)) - (64'd9 << 56);
            im = (rnd_im % (64'd12 << 56)) - (64'd6 << 56);
         end else if (kind < 71) begin
            // just right of the cusp at 0.25, slow escapes
            shift = $urandom_range(36, 50);
            eps = (64'd1 << shift) | (rnd_re & ((64'd1 << shift) - 64'd1));
            re = Q_QUARTER + eps;
            im = $signed({{32{rnd_im[31]}}, rnd_im[31:0]}) >>> 2;
         end else begin
            re = (rnd_re % (64'd32 << 56)) - (64'd16 << 56);
            im = (rnd_im % (64'd32 << 56)) - (64'd16 << 56);
         end
         drive_point(re, im, 1'b0, FIRST_BAND);
      end
      hold_off(1);

      waited = 0;
      while (pending_bands.size() != 0 && waited < 40000) begin
         @(posedge clock);
         waited++;
      end
      band_errors += pending_bands.size();
      repeat (40) @(posedge clock);
      if (band_errors == 0)
         $display("tb_mandelbrot_escape_band OK");
      else
         $display("tb_mandelbrot_escape_band NOT OK");
      $finish;
   end

endmodule

### filelist.f
sv/meb_pkg.sv
sv/meb_mac.sv
sv/meb_seq.sv
sv/mandelbrot_escape_band.sv
tb/tb_mandelbrot_escape_band.sv
